// ===== design/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cursor control package
// Shared payload types, command codes, control bytes and register indexes.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Configuration port widths
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_NUM_COLS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_NUM_ROWS = 2'd1;

  // Register reset values
  localparam logic [7:0] NUM_COLS_RST = 8'd80;
  localparam logic [6:0] NUM_ROWS_RST = 7'd25;

  // Console control bytes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Request kinds
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Renderer commands
  typedef enum logic [1:0] {
    CMD_CURSOR = 2'd0,
    CMD_DRAW   = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // One input item
  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } in_t;

  // One result item
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] cell_col;
    logic [6:0] cell_row;
    logic [7:0] glyph_code;
    logic       last;
  } out_t;

  // Step logic result toward the control registers
  typedef struct packed {
    out_t       beat;
    logic       final_beat;
    logic [7:0] next_col;
    logic [6:0] next_row;
  } step_t;

endpackage

// ===== design/tcc_step.sv =====
// ----------------------------------------------------------------------------
// Cursor step logic
// Resolves a pending wrap and scroll, applies one console byte or a clear
// request, and selects the result beat for the current phase.
// ----------------------------------------------------------------------------
module tcc_step (
  input  logic [7:0]   num_cols_i,
  input  logic [6:0]   num_rows_i,
  input  logic [7:0]   cur_col_i,
  input  logic [6:0]   cur_row_i,
  input  tcc_pkg::in_t item_i,
  input  logic         phase_i,
  output tcc_pkg::step_t step_o
);
  import tcc_pkg::*;

  logic [7:0] cols;
  logic [6:0] rows;
  logic       wrap;
  logic [7:0] col_a;
  logic [7:0] row_a;
  logic       scroll;
  logic [7:0] col_b;
  logic [6:0] row_b;
  logic [7:0] main_col;
  logic [6:0] main_row;
  logic [7:0] next_col;
  logic [6:0] next_row;
  cmd_e       main_cmd;
  logic [7:0] main_glyph;
  logic       two_beats;

  // Treat a zero-sized area as one cell wide or high
  assign cols = (num_cols_i == 8'd0) ? 8'd1 : num_cols_i;
  assign rows = (num_rows_i == 7'd0) ? 7'd1 : num_rows_i;

  // Wrap a cursor parked past the last column
  assign wrap  = (cur_col_i >= cols);
  assign col_a = wrap ? 8'd0 : cur_col_i;
  assign row_a = {1'b0, cur_row_i} + {7'd0, wrap};

  // Scroll when the row runs past the last one
  assign scroll = (row_a >= {1'b0, rows});
  assign row_b  = scroll ? (rows - 7'd1) : row_a[6:0];
  assign col_b  = scroll ? 8'd0 : col_a;

  // Apply the byte
  always_comb begin
    main_cmd   = CMD_CURSOR;
    main_glyph = 8'd0;
    main_col   = col_b;
    main_row   = row_b;
    next_col   = col_b;
    next_row   = row_b;
    unique case (item_i.char_code)
      CH_NUL: begin
      end
      CH_BS: begin
        if (col_b != 8'd0) begin
          main_col = col_b - 8'd1;
        end else if (row_b != 7'd0) begin
          main_row = row_b - 7'd1;
          main_col = cols - 8'd1;
        end
        next_col = main_col;
        next_row = main_row;
      end
      CH_LF: begin
        main_col = 8'd0;
        main_row = row_b + 7'd1;
        next_col = main_col;
        next_row = main_row;
      end
      CH_CR: begin
        main_col = 8'd0;
        next_col = 8'd0;
      end
      default: begin
        main_cmd   = CMD_DRAW;
        main_glyph = item_i.char_code;
        next_col   = col_b + 8'd1;
      end
    endcase
  end

  assign two_beats = (item_i.req_type == REQ_BYTE) && scroll;

  // Select the beat for this phase
  always_comb begin
    step_o = '0;
    if (item_i.req_type == REQ_CLEAR) begin
      step_o.beat.cmd   = CMD_CLEAR;
      step_o.beat.last  = 1'b1;
      step_o.final_beat = 1'b1;
    end else if (two_beats && !phase_i) begin
      step_o.beat.cmd      = CMD_SCROLL;
      step_o.beat.cell_row = rows - 7'd1;
      step_o.final_beat    = 1'b0;
      step_o.next_col      = cur_col_i;
      step_o.next_row      = cur_row_i;
    end else begin
      step_o.beat.cmd        = main_cmd;
      step_o.beat.cell_col   = main_col;
      step_o.beat.cell_row   = main_row;
      step_o.beat.glyph_code = main_glyph;
      step_o.beat.last       = 1'b1;
      step_o.final_beat      = 1'b1;
      step_o.next_col        = next_col;
      step_o.next_row        = next_row;
    end
  end

endmodule

// ===== design/text_console_cursor_control.sv =====
// ----------------------------------------------------------------------------
// Text console cursor control
// Keeps a text cursor and turns console bytes and clear requests into
// draw, scroll, cursor and clear commands for a downstream renderer.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_data_i         | item in
//  out     | out_valid_o, out_stall_i, out_data_o      | beat out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_idx_i/data  | reg write
//
//  An item goes from the input register through the step logic into the
//  output register as one beat, or two beats when a scroll comes first.
//  The input register holds the item until its last beat is loaded, so one
//  item a cycle is taken when no scroll occurs and the output is not stalled.
//  A stalled output holds its beat; the input stalls while the output
//  register cannot take the next beat, and while the scroll beat of a
//  two-beat item is loaded. Reset homes the cursor and loads 80 columns
//  by 25 rows.
module text_console_cursor_control (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tcc_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tcc_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tcc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import tcc_pkg::*;

  logic       in_valid_q, in_valid_d;
  in_t        in_q;
  logic       phase_q, phase_d;
  logic [7:0] cur_col_q;
  logic [6:0] cur_row_q;
  logic [7:0] num_cols_q;
  logic [6:0] num_rows_q;
  logic       out_valid_q, out_valid_d;
  out_t       out_q;
  step_t      step;
  logic       out_load;
  logic       item_done;
  logic       in_accept;
  logic       cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NUM_COLS_RST;
      num_rows_q <= NUM_ROWS_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_i)
        REG_NUM_COLS: num_cols_q <= cfg_data_i;
        REG_NUM_ROWS: num_rows_q <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  tcc_step u_step (
    .num_cols_i (num_cols_q),
    .num_rows_i (num_rows_q),
    .cur_col_i  (cur_col_q),
    .cur_row_i  (cur_row_q),
    .item_i     (in_q),
    .phase_i    (phase_q),
    .step_o     (step)
  );

  // Handshake control
  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign item_done  = out_load && step.final_beat;
  assign in_stall_o = in_valid_q && !item_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (item_done) begin
      in_valid_d = 1'b0;
    end
  end

  assign phase_d = out_load ? !step.final_beat : phase_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cur_col_q   <= 8'd0;
      cur_row_q   <= 7'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (item_done) begin
        cur_col_q <= step.next_col;
        cur_row_q <= step.next_row;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= step.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/tcc_checker.sv =====
// ----------------------------------------------------------------------------
// Text console cursor control checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input tcc_pkg::out_t out_data_o
);
  import tcc_pkg::*;

  // Hold a stalled beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // A scroll beat always leads, never ends an item
  a_scroll_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.cmd == CMD_SCROLL) |-> !out_data_o.last)
    else $error("scroll beat marked last");

  // Only a scroll beat may leave an item open
  a_open_is_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> (out_data_o.cmd == CMD_SCROLL))
    else $error("non-final beat is not a scroll");

  // Clear homes the cursor
  a_clear_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.cmd == CMD_CLEAR) |->
      (out_data_o.cell_col == 8'd0) && (out_data_o.cell_row == 7'd0))
    else $error("clear beat not at home cell");

  // Glyph is zero unless drawing
  a_glyph_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.cmd != CMD_DRAW) |-> (out_data_o.glyph_code == 8'd0))
    else $error("glyph set on non-draw beat");

endmodule

bind text_console_cursor_control tcc_checker u_tcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
